[rtl/fds_pkg.sv]
package fds_pkg;

  // Geometry defaults and fixed field widths
  localparam int MAX_COLS_DEF = 1024;
  localparam int ROW_SLOTS    = 4;
  localparam int SLOT_W       = $clog2(ROW_SLOTS);
  localparam int COLS_CFG_W   = 11;
  localparam int ROWS_W       = 16;
  localparam int SCALE_W      = 32;
  localparam int VAL_W        = 32;
  localparam int FLUX_W       = 48;
  localparam int DIV_W        = 48;
  localparam int IDX_W        = 8;
  localparam int DATA_W       = 32;

  // Stencil sums and the split scale multiply
  localparam int SUM_W  = FLUX_W + 2;
  localparam int HALF_W = SUM_W / 2;
  localparam int PROD_W = HALF_W + 1 + SCALE_W + 1;
  localparam int ACC_W  = SUM_W + SCALE_W + 2;
  localparam int RND_W  = 16;

  // Eight stencil reads, then the return of the last one from the registered read port
  localparam logic [3:0] RD_LAST = 4'd8;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_COLS    = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_ROWS    = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_SCALE_X = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_SCALE_Y = IDX_W'(3);

  typedef struct packed {
    logic [COLS_CFG_W-1:0] last_col;
    logic [ROWS_W-1:0]     last_row;
    logic [SCALE_W-1:0]    scale_x;
    logic [SCALE_W-1:0]    scale_y;
    logic                  restart;
  } fds_geom_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_WR,
    ST_SEL,
    ST_RD,
    ST_SGO,
    ST_SCL,
    ST_OUT
  } fds_state_t;

endpackage

[rtl/fds_in_if.sv]
interface fds_in_if import fds_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    cell_defined;
  logic signed [VAL_W-1:0] vel_x;
  logic signed [VAL_W-1:0] vel_y;
  logic signed [VAL_W-1:0] field_value;

  modport source (output valid, cell_defined, vel_x, vel_y, field_value, input ready);
  modport sink   (input valid, cell_defined, vel_x, vel_y, field_value, output ready);
endinterface

[rtl/fds_out_if.sv]
interface fds_out_if import fds_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DIV_W-1:0] divergence;
  logic                    result_defined;
  logic                    last_of_run;

  modport source (output valid, divergence, result_defined, last_of_run, input ready);
  modport sink   (input valid, divergence, result_defined, last_of_run, output ready);
endinterface

[rtl/fds_cfg_if.sv]
interface fds_cfg_if import fds_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  reg_index;
  logic [DATA_W-1:0] data;

  modport source (output valid, reg_index, data, input ready);
  modport sink   (input valid, reg_index, data, output ready);
endinterface

[rtl/fds_ram.sv]
module fds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/fds_regs.sv]
module fds_regs import fds_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  fds_cfg_if.sink   cfg_ch,
  output fds_geom_t geom_o
);

  logic [COLS_CFG_W-1:0] cols_r;
  logic [ROWS_W-1:0]     rows_r;
  logic [SCALE_W-1:0]    scale_x_r;
  logic [SCALE_W-1:0]    scale_y_r;
  logic                  wr;
  logic [15:0]           cols_w;
  logic [15:0]           cols_eff;
  logic [ROWS_W-1:0]     rows_eff;

  assign cfg_ch.ready = 1'b1;
  assign wr = cfg_ch.valid && cfg_ch.ready;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r    <= COLS_CFG_W'(1024);
      rows_r    <= ROWS_W'(2);
      scale_x_r <= SCALE_W'(65536);
      scale_y_r <= SCALE_W'(65536);
    end else if (wr) begin
      unique case (cfg_ch.reg_index)
        REG_COLS:    cols_r    <= cfg_ch.data[COLS_CFG_W-1:0];
        REG_ROWS:    rows_r    <= cfg_ch.data[ROWS_W-1:0];
        REG_SCALE_X: scale_x_r <= cfg_ch.data[SCALE_W-1:0];
        REG_SCALE_Y: scale_y_r <= cfg_ch.data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp geometry into the supported range
  assign cols_w   = 16'(cols_r);
  assign cols_eff = (cols_w < 16'd2) ? 16'd2 :
                    (cols_w > 16'(MAX_COLS)) ? 16'(MAX_COLS) : cols_w;
  assign rows_eff = (rows_r < ROWS_W'(2)) ? ROWS_W'(2) : rows_r;

  assign geom_o.last_col = COLS_CFG_W'(cols_eff - 16'd1);
  assign geom_o.last_row = rows_eff - ROWS_W'(1);
  assign geom_o.scale_x  = scale_x_r;
  assign geom_o.scale_y  = scale_y_r;
  // a geometry write restarts the frame
  assign geom_o.restart  = wr && (cfg_ch.reg_index == REG_COLS ||
                                  cfg_ch.reg_index == REG_ROWS);

endmodule

[rtl/fds_scale.sv]
module fds_scale import fds_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start_i,
  input  logic signed [SUM_W-1:0] sx_i,
  input  logic signed [SUM_W-1:0] sy_i,
  input  logic [SCALE_W-1:0]      scale_x_i,
  input  logic [SCALE_W-1:0]      scale_y_i,
  output logic                    done_o,
  output logic signed [DIV_W-1:0] div_o
);

  logic                     busy_r;
  logic [2:0]               step_r;
  logic                     done_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     sh_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [DIV_W-1:0]  div_r;
  logic signed [HALF_W:0]   a_op;
  logic signed [SCALE_W:0]  b_op;
  logic signed [SUM_W-1:0]  sum_sel;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [ACC_W-1:0]  quo;
  logic [ACC_W-DIV_W:0]     quo_hi;
  logic signed [DIV_W-1:0]  sat;

  // Operand select: low then high half of Sx, then of Sy
  always_comb begin
    sum_sel = step_r[1] ? sy_i : sx_i;
    b_op    = {1'b0, (step_r[1] ? scale_y_i : scale_x_i)};
    if (step_r[0]) begin
      a_op = {sum_sel[SUM_W-1], sum_sel[SUM_W-1:HALF_W]};
    end else begin
      a_op = {1'b0, sum_sel[HALF_W-1:0]};
    end
  end

  assign prod_ext = sh_r ? (ACC_W'(prod_r) <<< HALF_W) : ACC_W'(prod_r);

  // Round half up, drop the fraction, saturate
  assign rnd    = acc_r + ACC_W'(32768);
  assign quo    = rnd >>> RND_W;
  assign quo_hi = quo[ACC_W-1:DIV_W-1];
  always_comb begin
    if ((&quo_hi) || !(|quo_hi)) begin
      sat = quo[DIV_W-1:0];
    end else if (quo[ACC_W-1]) begin
      sat = {1'b1, {(DIV_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(DIV_W-1){1'b1}}};
    end
  end

  // Sequencer: four products, four accumulates, one rounding step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 3'd0;
      done_r <= 1'b0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      step_r <= 3'd0;
      done_r <= 1'b0;
    end else if (busy_r) begin
      step_r <= step_r + 3'd1;
      if (step_r == 3'd5) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      acc_r <= '0;
    end else if (busy_r) begin
      if (step_r < 3'd4) begin
        prod_r <= a_op * b_op;
        sh_r   <= step_r[0];
      end
      if (step_r >= 3'd1 && step_r <= 3'd4) begin
        acc_r <= acc_r + prod_ext;
      end
      if (step_r == 3'd5) begin
        div_r <= sat;
      end
    end
  end

  assign done_o = done_r;
  assign div_o  = div_r;

endmodule

[rtl/flux_divergence_stencil.sv]
// Sequence: a taken request is multiplied into fluxes (ST_MUL) and written to the line
//   memory (ST_WR); each result it causes then needs select, 8 memory reads, start, the
//   split scale multiply and an output load that waits for a free output register.
// Requests: a new request is taken only after every result of the last one (0 to 3)
//   has been loaded for output; all reads share the single read port of the line memory.
// Reset: synchronous, active low; clears counters, sequencer and output valid.
module flux_divergence_stencil import fds_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  fds_in_if.sink     in_ch,
  fds_out_if.source  out_ch,
  fds_cfg_if.sink    cfg_ch
);

  localparam int CW    = $clog2(MAX_COLS);
  localparam int AW    = SLOT_W + CW;
  localparam int DEPTH = ROW_SLOTS * (2 ** CW);
  localparam int MW    = 1 + 2 * FLUX_W;

  fds_geom_t  geom;
  fds_state_t state_r, state_nxt;

  logic [CW-1:0]     last_col;
  logic [ROWS_W-1:0] last_row;

  // frame position
  logic [ROWS_W-1:0] row_r;
  logic [CW-1:0]     col_r;
  logic [CW-1:0]     c_in;

  // current request
  logic [ROWS_W-1:0]       cur_row_r;
  logic [CW-1:0]           cur_col_r;
  logic                    cur_def_r;
  logic signed [VAL_W-1:0] vx_r, vy_r, fv_r;
  logic signed [63:0]      pfx_r, pfy_r;
  logic signed [63:0]      fxr, fyr;
  logic [2:0]              jobs_r;

  // current result cell
  logic [ROWS_W-1:0]       k_r;
  logic [CW-1:0]           l_r;
  logic                    last_r;
  logic [3:0]              rd_cnt_r;
  logic signed [SUM_W-1:0] sx_r, sy_r;
  logic                    def_acc_r;

  // job pick
  logic [ROWS_W-1:0] job_k;
  logic [CW-1:0]     job_l;
  logic [2:0]        job_rest;

  // stencil indexes
  logic [CW-1:0]     lp, l1, l2, ln;
  logic [ROWS_W-1:0] kp, k1, k2, kn;
  logic [2:0]        rd_sel;
  logic [2:0]        use_sel;

  // memory
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [MW-1:0] ram_wdata, ram_rdata;
  logic signed [FLUX_W-1:0] rd_val;

  // scale unit and output
  logic                    scl_start;
  logic                    scl_done;
  logic signed [DIV_W-1:0] scl_div;
  logic                    in_acc;
  logic                    out_load;
  logic                    out_valid_r;
  logic signed [DIV_W-1:0] out_div_r;
  logic                    out_def_r;
  logic                    out_last_r;

  fds_regs #(.MAX_COLS(MAX_COLS)) u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .geom_o (geom)
  );

  assign last_col = CW'(geom.last_col);
  assign last_row = geom.last_row;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_WR;
      ST_WR:   state_nxt = ST_SEL;
      ST_SEL:  state_nxt = (jobs_r == 3'b000) ? ST_IDLE : ST_RD;
      ST_RD:   if (rd_cnt_r == RD_LAST) state_nxt = ST_SGO;
      ST_SGO:  state_nxt = ST_SCL;
      ST_SCL:  if (scl_done) state_nxt = ST_OUT;
      ST_OUT:  if (out_load) state_nxt = ST_SEL;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ch.ready = (state_r == ST_IDLE);
    ram_we      = (state_r == ST_WR);
    scl_start   = (state_r == ST_SGO);
    out_load    = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);
  end

  assign in_acc = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Frame position and pending results
  assign c_in = (col_r > last_col) ? last_col : col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      jobs_r <= 3'b000;
    end else if (geom.restart) begin
      row_r <= '0;
      col_r <= '0;
    end else if (in_acc) begin
      jobs_r[0] <= (row_r != '0);
      jobs_r[1] <= (row_r == last_row) && (c_in != '0);
      jobs_r[2] <= (row_r == last_row) && (c_in == last_col);
      if (c_in == last_col) begin
        col_r <= '0;
        row_r <= (row_r == last_row) ? '0 : row_r + ROWS_W'(1);
      end else begin
        col_r <= c_in + CW'(1);
      end
    end else if (state_r == ST_SEL) begin
      jobs_r <= job_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_row_r <= row_r;
      cur_col_r <= c_in;
      cur_def_r <= in_ch.cell_defined;
      vx_r      <= in_ch.vel_x;
      vy_r      <= in_ch.vel_y;
      fv_r      <= in_ch.field_value;
    end
    if (state_r == ST_MUL) begin
      pfx_r <= vx_r * fv_r;
      pfy_r <= vy_r * fv_r;
    end
  end

  // Flux products rounded to Q32.16; they cannot leave 48 bits
  assign fxr = (pfx_r + 64'sd32768) >>> RND_W;
  assign fyr = (pfy_r + 64'sd32768) >>> RND_W;

  assign ram_waddr = {cur_row_r[SLOT_W-1:0], cur_col_r};
  assign ram_wdata = {cur_def_r, fxr[FLUX_W-1:0], fyr[FLUX_W-1:0]};

  // Pick the next result cell, oldest row first
  always_comb begin
    if (jobs_r[0]) begin
      job_k    = cur_row_r - ROWS_W'(1);
      job_l    = cur_col_r;
      job_rest = jobs_r & 3'b110;
    end else if (jobs_r[1]) begin
      job_k    = cur_row_r;
      job_l    = cur_col_r - CW'(1);
      job_rest = jobs_r & 3'b100;
    end else begin
      job_k    = cur_row_r;
      job_l    = cur_col_r;
      job_rest = 3'b000;
    end
  end

  // Clamped stencil around (k, l)
  assign lp = ({1'b0, l_r} >= (CW + 1)'(2)) ? l_r - CW'(2) : '0;
  assign l1 = lp + CW'(1);
  assign ln = (l_r == last_col) ? l_r : l_r + CW'(1);
  assign l2 = ln - CW'(1);
  assign kp = (k_r >= ROWS_W'(2)) ? k_r - ROWS_W'(2) : '0;
  assign k1 = kp + ROWS_W'(1);
  assign kn = (k_r == last_row) ? k_r : k_r + ROWS_W'(1);
  assign k2 = kn - ROWS_W'(1);

  // Read address: four along the row (x flux), four down the column (y flux)
  assign rd_sel = rd_cnt_r[2:0];
  always_comb begin
    case (rd_sel)
      3'd0:    ram_raddr = {k_r[SLOT_W-1:0], lp};
      3'd1:    ram_raddr = {k_r[SLOT_W-1:0], l1};
      3'd2:    ram_raddr = {k_r[SLOT_W-1:0], l2};
      3'd3:    ram_raddr = {k_r[SLOT_W-1:0], ln};
      3'd4:    ram_raddr = {kp[SLOT_W-1:0], l_r};
      3'd5:    ram_raddr = {k1[SLOT_W-1:0], l_r};
      3'd6:    ram_raddr = {k2[SLOT_W-1:0], l_r};
      default: ram_raddr = {kn[SLOT_W-1:0], l_r};
    endcase
  end

  fds_ram #(.WIDTH(MW), .DEPTH(DEPTH)) u_lines (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Data returning now belongs to the previous read
  assign use_sel = 3'(rd_cnt_r - 4'd1);
  assign rd_val  = use_sel[2] ? ram_rdata[FLUX_W-1:0] : ram_rdata[2*FLUX_W-1:FLUX_W];

  // Gather the stencil sums
  always_ff @(posedge clk) begin
    if (state_r == ST_SEL) begin
      k_r       <= job_k;
      l_r       <= job_l;
      last_r    <= (job_rest == 3'b000);
      rd_cnt_r  <= '0;
      sx_r      <= '0;
      sy_r      <= '0;
      def_acc_r <= 1'b0;
    end else if (state_r == ST_RD) begin
      rd_cnt_r <= rd_cnt_r + 4'd1;
      if (rd_cnt_r != 4'd0) begin
        def_acc_r <= def_acc_r | ram_rdata[MW-1];
        if (use_sel[2]) begin
          sy_r <= use_sel[0] ? sy_r - SUM_W'(rd_val) : sy_r + SUM_W'(rd_val);
        end else begin
          sx_r <= use_sel[0] ? sx_r - SUM_W'(rd_val) : sx_r + SUM_W'(rd_val);
        end
      end
    end
  end

  fds_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_i   (scl_start),
    .sx_i      (sx_r),
    .sy_i      (sy_r),
    .scale_x_i (geom.scale_x),
    .scale_y_i (geom.scale_y),
    .done_o    (scl_done),
    .div_o     (scl_div)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_div_r  <= def_acc_r ? scl_div : '0;
      out_def_r  <= def_acc_r;
      out_last_r <= last_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.divergence     = out_div_r;
  assign out_ch.result_defined = out_def_r;
  assign out_ch.last_of_run    = out_last_r;

  // Checks
  a_idle_no_jobs: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> jobs_r == 3'b000)
    else $error("pending results left when idle");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= last_col)
    else $error("column counter past last column");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= last_row)
    else $error("row counter past last row");

  a_scale_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCL && scl_done) |=> state_r == ST_OUT)
    else $error("scale result not taken");

  a_wait_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && !out_load) |-> out_valid_r)
    else $error("waiting on an empty output register");

endmodule

[tb/sv/flux_divergence_stencil_tb.sv]
module flux_divergence_stencil_tb;
  import fds_pkg::*;

  localparam int MEM_COLS   = 1024;
  localparam int DRAIN_WAIT = 100;
  localparam int STALL_MAX  = 2000;
  localparam logic signed [127:0] DIV_MAX = 128'sd140737488355327;
  localparam logic signed [127:0] DIV_MIN = -128'sd140737488355328;

  typedef struct packed {
    logic signed [DIV_W-1:0] divergence;
    logic                    result_defined;
    logic                    last_of_run;
  } div_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  fds_in_if  in_ch ();
  fds_out_if out_ch ();
  fds_cfg_if cfg_ch ();

  flux_divergence_stencil i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  always #4 clk = ~clk;

  // Predictor state: line slots, frame position, registers
  logic signed [FLUX_W-1:0] flux_x_mem [ROW_SLOTS*MEM_COLS];
  logic signed [FLUX_W-1:0] flux_y_mem [ROW_SLOTS*MEM_COLS];
  logic                     def_mem    [ROW_SLOTS*MEM_COLS];
  int unsigned row_pos, col_pos, base_slot;
  int unsigned cols_reg, rows_reg;
  logic [SCALE_W-1:0] scale_x_reg, scale_y_reg;

  div_result_t expected_divs[$];
  int errors     = 0;
  int cells_sent = 0;
  int burst_left = 0;
  int hold_cycles = 0;
  int idle_cycles = 0;

  function automatic logic signed [DIV_W-1:0] clip48(logic signed [127:0] v);
    if (v > DIV_MAX) return DIV_MAX[DIV_W-1:0];
    if (v < DIV_MIN) return DIV_MIN[DIV_W-1:0];
    return v[DIV_W-1:0];
  endfunction

  function automatic logic signed [FLUX_W-1:0] flux_prod(logic signed [31:0] a,
                                                         logic signed [31:0] b);
    logic signed [63:0]  p;
    logic signed [127:0] w;
    p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
    p = p + 64'sd32768;
    w = p >>> 16;
    return clip48(w);
  endfunction

  function automatic int unsigned slot_ix(int unsigned k, int unsigned l);
    return ((base_slot + k - row_pos) & (ROW_SLOTS - 1)) * MEM_COLS + l;
  endfunction

  function automatic div_result_t stencil_div(int unsigned k, int unsigned l,
                                              int unsigned nr, int unsigned nc);
    int unsigned lp, l1, ln, l2, kp, k1, kn, k2;
    logic signed [127:0] sxs, sys, acc;
    div_result_t r;
    lp = (l >= 2) ? l - 2 : 0;  l1 = lp + 1;
    ln = (l + 1 < nc) ? l + 1 : nc - 1;  l2 = ln - 1;
    kp = (k >= 2) ? k - 2 : 0;  k1 = kp + 1;
    kn = (k + 1 < nr) ? k + 1 : nr - 1;  k2 = kn - 1;
    r.result_defined = def_mem[slot_ix(k, l)] | def_mem[slot_ix(k, ln)] |
                       def_mem[slot_ix(kp, l)] | def_mem[slot_ix(k, lp)] |
                       def_mem[slot_ix(k, l1)] | def_mem[slot_ix(k1, l)] |
                       def_mem[slot_ix(kn, l)];
    r.divergence = '0;
    r.last_of_run = 1'b0;
    if (r.result_defined) begin
      sxs = flux_x_mem[slot_ix(k, lp)];
      sxs = sxs - flux_x_mem[slot_ix(k, l1)] + flux_x_mem[slot_ix(k, l2)]
            - flux_x_mem[slot_ix(k, ln)];
      sys = flux_y_mem[slot_ix(kp, l)];
      sys = sys - flux_y_mem[slot_ix(k1, l)] + flux_y_mem[slot_ix(k2, l)]
            - flux_y_mem[slot_ix(kn, l)];
      acc = sxs * $signed({96'd0, scale_x_reg}) + sys * $signed({96'd0, scale_y_reg});
      acc = (acc + 128'sd32768) >>> 16;
      r.divergence = clip48(acc);
    end
    return r;
  endfunction

  // Store one accepted cell and queue the divergences it releases
  task automatic predict_cell(logic d, logic signed [31:0] vx, logic signed [31:0] vy,
                              logic signed [31:0] fv);
    int unsigned nc, nr, r, c, ix, n;
    div_result_t res [3];
    nc = (cols_reg < 2) ? 2 : ((cols_reg > MEM_COLS) ? MEM_COLS : cols_reg);
    nr = (rows_reg < 2) ? 2 : rows_reg;
    r = row_pos;
    c = (col_pos >= nc) ? nc - 1 : col_pos;
    ix = slot_ix(r, c);
    def_mem[ix] = d;
    flux_x_mem[ix] = flux_prod(vx, fv);
    flux_y_mem[ix] = flux_prod(vy, fv);
    n = 0;
    if (r >= 1) res[n++] = stencil_div(r - 1, c, nr, nc);
    if (r == nr - 1 && c >= 1) res[n++] = stencil_div(r, c - 1, nr, nc);
    if (r == nr - 1 && c == nc - 1) res[n++] = stencil_div(r, c, nr, nc);
    if (n > 0) res[n-1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) expected_divs.push_back(res[i]);
    col_pos = c + 1;
    if (col_pos >= nc) begin
      col_pos = 0;
      row_pos = r + 1;
      base_slot = (base_slot + 1) & (ROW_SLOTS - 1);
      if (row_pos >= nr) begin
        row_pos = 0;
        base_slot = 0;
      end
    end
  endtask

  // One cell request, sent in bursts with random gaps
  task automatic send_cell(logic d, logic signed [31:0] vx, logic signed [31:0] vy,
                           logic signed [31:0] fv);
    if (burst_left == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_ch.valid = 1'b1;
    in_ch.cell_defined = d;
    in_ch.vel_x = vx;
    in_ch.vel_y = vy;
    in_ch.field_value = fv;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_cell(d, vx, vy, fv);
    cells_sent++;
    burst_left--;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    cfg_ch.valid = 1'b1;
    cfg_ch.reg_index = idx;
    cfg_ch.data = data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_COLS:    cols_reg = data[COLS_CFG_W-1:0];
      REG_ROWS:    rows_reg = data[ROWS_W-1:0];
      REG_SCALE_X: scale_x_reg = data;
      REG_SCALE_Y: scale_y_reg = data;
      default: ;
    endcase
    if (idx == REG_COLS || idx == REG_ROWS) begin
      row_pos = 0;
      col_pos = 0;
      base_slot = 0;
    end
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Wait for all expected divergences, then for the pipeline to settle
  task automatic drain();
    while (expected_divs.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_frame(int unsigned nc, int unsigned nr,
                           logic [31:0] sx, logic [31:0] sy);
    drain();
    write_reg(REG_COLS, nc);
    write_reg(REG_ROWS, nr);
    write_reg(REG_SCALE_X, sx);
    write_reg(REG_SCALE_Y, sy);
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
    endcase
  endfunction

  function automatic logic [31:0] rand_scale();
    case ($urandom_range(0, 4))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      default: return $urandom_range(0, 1 << 18);
    endcase
  endfunction

  task automatic send_random(int n, int def_pct);
    for (int i = 0; i < n; i++)
      send_cell($urandom_range(1, 100) <= def_pct, rand_val(), rand_val(), rand_val());
  endtask

  // Extremes of every field on a small frame, then an all-undefined frame and a frame with a single defined cell
  task automatic test_directed();
    logic [31:0] ext [4];
    ext = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
    set_frame(4, 3, 32'h0001_0000, 32'h0001_0000);
    for (int i = 0; i < 12; i++)
      send_cell(i % 3 != 1, ext[i % 4], ext[(i + 1) % 4], ext[(i / 2) % 4]);
    set_frame(2, 2, 32'hFFFF_FFFF, 32'h0);
    for (int i = 0; i < 4; i++) send_cell(1'b0, ext[i], ext[3 - i], ext[i]);
    set_frame(3, 2, 32'h0, 32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++) send_cell(i == 2, 32'h7FFF_FFFF, 32'h8000_0000, ext[i % 4]);
  endtask

  // Clamped geometry, oversized column count, tallest frame, ignored register index
  task automatic test_geometry();
    set_frame(0, 0, 32'h0001_0000, 32'h0000_8000);
    send_random(4, 70);
    set_frame(2047, 2, rand_scale(), rand_scale());
    send_random(40, 60);
    set_frame(3, 65535, rand_scale(), rand_scale());
    send_random(15, 60);
    drain();
    write_reg(IDX_W'(5), $urandom());
    send_random(6, 60);
  endtask

  // Random frames, some cut short by a geometry change
  task automatic test_random();
    int nc, nr, n;
    while (cells_sent < 300) begin
      nc = $urandom_range(0, 5) == 0 ? $urandom_range(17, 40) : $urandom_range(2, 9);
      nr = $urandom_range(2, 6);
      set_frame(nc, nr, rand_scale(), rand_scale());
      n = nc * nr;
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
      send_random(n, $urandom_range(0, 3) == 0 ? 10 : 80);
    end
  endtask

  // Receiver holds off while requests keep coming
  task automatic test_backpressure();
    set_frame(8, 4, rand_scale(), rand_scale());
    hold_cycles = 400;
    send_random(32, 80);
  endtask

  // Receiver stall pattern, with an optional long hold-off
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase++;
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ch.ready = 1'b0;
    end else begin
      case ((stall_phase / 150) % 3)
        0: out_ch.ready = 1'b1;
        1: out_ch.ready = $urandom_range(0, 3) != 0;
        default: out_ch.ready = $urandom_range(0, 9) < 3;
      endcase
    end
  end

  // Compare each divergence with the oldest expectation
  always @(posedge clk) begin
    div_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_divs.size() == 0) begin
        $error("unexpected divergence %0d", out_ch.divergence);
        errors++;
      end else begin
        exp_r = expected_divs.pop_front();
        if (out_ch.divergence !== exp_r.divergence) begin
          $error("divergence expected %0d actual %0d", exp_r.divergence,
                 out_ch.divergence);
          errors++;
        end
        if (out_ch.result_defined !== exp_r.result_defined) begin
          $error("result_defined expected %0b actual %0b", exp_r.result_defined,
                 out_ch.result_defined);
          errors++;
        end
        if (out_ch.last_of_run !== exp_r.last_of_run) begin
          $error("last_of_run expected %0b actual %0b", exp_r.last_of_run,
                 out_ch.last_of_run);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no request moving
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_MAX) begin
      $display("flux_divergence_stencil: mismatch");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cell_defined = 1'b0;
    in_ch.vel_x = '0;
    in_ch.vel_y = '0;
    in_ch.field_value = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_index = '0;
    cfg_ch.data = '0;
    row_pos = 0;
    col_pos = 0;
    base_slot = 0;
    cols_reg = 1024;
    rows_reg = 2;
    scale_x_reg = 32'h0001_0000;
    scale_y_reg = 32'h0001_0000;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_geometry();
    test_backpressure();
    test_random();
    drain();
    if (errors == 0 && expected_divs.size() == 0)
      $display("flux_divergence_stencil: match");
    else
      $display("flux_divergence_stencil: mismatch");
    $finish;
  end

endmodule

[filelist.f]
rtl/fds_pkg.sv
rtl/fds_in_if.sv
rtl/fds_out_if.sv
rtl/fds_cfg_if.sv
rtl/fds_ram.sv
rtl/fds_regs.sv
rtl/fds_scale.sv
rtl/flux_divergence_stencil.sv
tb/sv/flux_divergence_stencil_tb.sv
